// ===== rtl/core/pfd_pkg.sv =====
`timescale 1ns / 1ps
package pfd_pkg;

    // quotient bits resolved by each division chain
    localparam int PSC_STEPS = 12;
    localparam int RLD_STEPS = 28;
    localparam int CMP_STEPS = 18;

    localparam logic [27:0] CLOCK_RESET = 28'd72000000;
    localparam logic [39:0] DUTY_FULL   = 40'd10000;
    localparam logic [15:0] MAX16       = 16'hFFFF;

    // one item in flight plus its long-division state
    typedef struct packed {
        logic        vld;
        logic        fz;
        logic [13:0] duty;
        logic [26:0] freq;
        logic [15:0] psc;
        logic [15:0] arr;
        logic [30:0] num;
        logic [39:0] rem;
        logic [39:0] den;
        logic [27:0] quot;
    } pfd_tok_t;

endpackage

// ===== rtl/core/pwm_freq_duty_to_timer_regs_top.sv =====
`timescale 1ns / 1ps
// Turns a PWM frequency and duty into timer prescaler, reload and compare
// values. Items flow through a row of long-division cells (12 for the
// prescaler, 28 for the reload, 18 for the compare) with three link stages
// and an output register, and one new item is accepted every cycle while
// the output side takes results. The whole row stalls while a result waits.
// A zero frequency gives applied low and all values zero. The user is to
// write clock_hz only while idle; the block itself does not enforce it.
module pwm_freq_duty_to_timer_regs_top
    import pfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [27:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [26:0] target_freq_hz,
    input  logic [13:0] duty_hundredths,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        applied,
    output logic [15:0] prescaler_value,
    output logic [15:0] reload_value,
    output logic [15:0] compare_value
);

    logic [27:0] clock_hz_reg;
    logic        en;
    pfd_tok_t    a_tok [0:PSC_STEPS];
    pfd_tok_t    b_tok [0:RLD_STEPS];
    pfd_tok_t    c_tok [0:CMP_STEPS];
    logic        out_vld_reg;
    logic        applied_reg;
    logic [15:0] psc_reg;
    logic [15:0] arr_reg;
    logic [15:0] ccr_reg;
    logic [15:0] ccr_next;

    // clock register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clock_hz_reg <= CLOCK_RESET;
        else if (cfg_we)
            clock_hz_reg <= cfg_data;
    end

    assign en       = !out_vld_reg || out_ready;
    assign in_ready = en;

    // load prescaler division: (clock >> 16) / freq
    always_comb
    begin
        a_tok[0]      = '0;
        a_tok[0].vld  = in_valid;
        a_tok[0].fz   = (target_freq_hz == 27'd0);
        a_tok[0].freq = target_freq_hz;
        a_tok[0].duty = duty_hundredths;
        a_tok[0].num  = {clock_hz_reg[27:16], 19'd0};
        a_tok[0].den  = 40'(target_freq_hz);
    end

    // prescaler chain
    for (genvar i = 0; i < PSC_STEPS; i++)
    begin : g_psc
        pfd_div_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en), .d(a_tok[i]), .q(a_tok[i+1]));
    end

    pfd_reload_link u_rld_link (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .clock_hz (clock_hz_reg),
        .d        (a_tok[PSC_STEPS]),
        .q        (b_tok[0])
    );

    // reload chain
    for (genvar i = 0; i < RLD_STEPS; i++)
    begin : g_rld
        pfd_div_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en), .d(b_tok[i]), .q(b_tok[i+1]));
    end

    pfd_compare_link u_cmp_link (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .d     (b_tok[RLD_STEPS]),
        .q     (c_tok[0])
    );

    // compare chain
    for (genvar i = 0; i < CMP_STEPS; i++)
    begin : g_cmp
        pfd_div_cell u_cell (.clk(clk), .rst_n(rst_n), .en(en), .d(c_tok[i]), .q(c_tok[i+1]));
    end

    // compare saturation
    assign ccr_next = (c_tok[CMP_STEPS].quot[17:16] != 2'd0) ? MAX16
                                                            : c_tok[CMP_STEPS].quot[15:0];

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= c_tok[CMP_STEPS].vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            applied_reg <= !c_tok[CMP_STEPS].fz;
            psc_reg     <= c_tok[CMP_STEPS].fz ? 16'd0 : c_tok[CMP_STEPS].psc;
            arr_reg     <= c_tok[CMP_STEPS].fz ? 16'd0 : c_tok[CMP_STEPS].arr;
            ccr_reg     <= c_tok[CMP_STEPS].fz ? 16'd0 : ccr_next;
        end
    end

    assign out_valid       = out_vld_reg;
    assign applied         = applied_reg;
    assign prescaler_value = psc_reg;
    assign reload_value    = arr_reg;
    assign compare_value   = ccr_reg;

    // applied items carry a prescaler inside its reachable range
    a_psc_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && applied |-> prescaler_value != 16'd0 && prescaler_value < 16'd4096)
        else $error("prescaler out of range");

    // rejected items carry all zero values
    a_rejected_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !applied |->
            prescaler_value == 16'd0 && reload_value == 16'd0 && compare_value == 16'd0)
        else $error("rejected item has nonzero values");

    // a stalled result is held by the output register
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(compare_value))
        else $error("result lost while stalled");

endmodule

// ===== rtl/core/pfd_div_cell.sv =====
`timescale 1ns / 1ps
module pfd_div_cell
    import pfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  pfd_tok_t d,
    output pfd_tok_t q
);

    pfd_tok_t   tok_reg;
    pfd_tok_t   tok_next;
    logic [40:0] rem2;
    logic        ge;

    // one restoring division step
    always_comb
    begin
        rem2     = {d.rem, d.num[30]};
        ge       = rem2 >= {1'b0, d.den};
        tok_next = d;
        tok_next.rem  = ge ? 40'(rem2 - {1'b0, d.den}) : rem2[39:0];
        tok_next.quot = {d.quot[26:0], ge};
        tok_next.num  = {d.num[29:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= tok_next;
    end

    assign q = tok_reg;

endmodule

// ===== rtl/core/pfd_reload_link.sv =====
`timescale 1ns / 1ps
module pfd_reload_link
    import pfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [27:0] clock_hz,
    input  pfd_tok_t    d,
    output pfd_tok_t    q
);

    pfd_tok_t    tok_reg;
    pfd_tok_t    tok_next;
    logic [11:0] psc;
    logic [12:0] psc_p1;

    // clamp prescaler, set up clock / (freq * (psc + 1))
    always_comb
    begin
        psc      = (d.quot[11:0] == 12'd0) ? 12'd1 : d.quot[11:0];
        psc_p1   = {1'b0, psc} + 13'd1;
        tok_next = d;
        tok_next.psc  = {4'd0, psc};
        tok_next.den  = 40'(40'(d.freq) * 40'(psc_p1));
        tok_next.num  = {clock_hz, 3'b000};
        tok_next.rem  = '0;
        tok_next.quot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (en)
            tok_reg <= tok_next;
    end

    assign q = tok_reg;

endmodule

// ===== rtl/core/pfd_compare_link.sv =====
`timescale 1ns / 1ps
module pfd_compare_link
    import pfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  pfd_tok_t d,
    output pfd_tok_t q
);

    pfd_tok_t    arr_reg;
    pfd_tok_t    arr_next;
    pfd_tok_t    tok_reg;
    pfd_tok_t    tok_next;
    logic [16:0] arr_p1;
    logic [30:0] prod;

    // reload from quotient, no underflow, clamp to 16 bits
    always_comb
    begin
        arr_next = d;
        if (d.quot == 28'd0)
            arr_next.arr = '0;
        else if (d.quot > 28'd65536)
            arr_next.arr = MAX16;
        else
            arr_next.arr = 16'(d.quot - 28'd1);
    end

    // duty * (reload + 1), set up division by full scale
    always_comb
    begin
        arr_p1   = {1'b0, arr_reg.arr} + 17'd1;
        prod     = 31'(31'(arr_reg.duty) * 31'(arr_p1));
        tok_next = arr_reg;
        tok_next.rem  = 40'(prod[30:18]);
        tok_next.num  = {prod[17:0], 13'd0};
        tok_next.den  = DUTY_FULL;
        tok_next.quot = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arr_reg <= '0;
            tok_reg <= '0;
        end
        else if (en)
        begin
            arr_reg <= arr_next;
            tok_reg <= tok_next;
        end
    end

    assign q = tok_reg;

endmodule
